FILE: hdl/voxel_grid_trilinear_sampler_core_macros.svh
// Assertion macros shared by the voxel grid sampler RTL.
`ifndef VOXEL_GRID_TRILINEAR_SAMPLER_CORE_MACROS_SVH
`define VOXEL_GRID_TRILINEAR_SAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define VGTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define VGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define VGTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/vgts_pkg.sv
// Shared widths, constants and queue entry types of the voxel grid sampler.
package vgts_pkg;

    localparam int DENS_W    = 16;
    localparam int POS_W     = 14;
    localparam int EXT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam int AXIS_X = 2;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 0;

    typedef struct packed {
        logic                     sample;
        logic [2:0]               lo_ok;
        logic [2:0]               hi_ok;
        logic [IDX_W-1:0]         x0;
        logic [IDX_W-1:0]         x1;
        logic [IDX_W-1:0]         y0;
        logic [IDX_W-1:0]         y1;
        logic [IDX_W-1:0]         z0;
        logic [IDX_W-1:0]         z1;
        logic [FRAC_W-1:0]        fx;
        logic [FRAC_W-1:0]        fy;
        logic [FRAC_W-1:0]        fz;
        logic signed [DENS_W-1:0] density;
    } t_cmd;

    typedef struct packed {
        logic signed [DENS_W-1:0] density;
        logic                     dropped;
    } t_res;

endpackage

FILE: hdl/voxel_grid_trilinear_sampler_core.sv
// Voxel grid trilinear sampler. Items enter through a push/full queue port and
// results leave through an empty/pop queue port, one result per item, in order.
// The front end classifies an item in the cycle of its transfer and queues up to
// two commands. The back end runs one command at a time: a write passes through
// dispatch, write and result states; a sample makes eight reads of the single-port
// cell memory, waits out the read latency, and runs seven lerps (a multiply and an
// add step each) on one shared multiplier. Up to two results wait in the
// output queue. The cell memory holds 2^(3*ceil(log2(MAX_EXTENT))) entries and
// has no reset; a cell read before it was written returns an undefined value.
// Configuration must be written only while no item is in flight.
`include "voxel_grid_trilinear_sampler_core_macros.svh"

module voxel_grid_trilinear_sampler_core #(
    parameter int MAX_EXTENT    = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_op,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [vgts_pkg::DENS_W-1:0]  i_new_density,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [vgts_pkg::DENS_W-1:0]  o_sampled_density,
    output logic                                o_write_dropped,
    input  logic                                i_cfg_we,
    input  logic [vgts_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [vgts_pkg::DENS_W-1:0]         i_cfg_wdata
);

    logic                               cmd_push;
    logic                               cmd_full;
    logic                               cmd_pop;
    logic                               cmd_empty;
    vgts_pkg::t_cmd                     cmd_in;
    vgts_pkg::t_cmd                     cmd_out;
    logic                               res_push;
    logic                               res_full;
    vgts_pkg::t_res                     res_in;
    vgts_pkg::t_res                     res_out;
    logic signed [vgts_pkg::DENS_W-1:0] empty_density;

    vgts_front #(
        .MAX_EXTENT    (MAX_EXTENT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_op            (i_op),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_new_density   (i_new_density),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_full        (cmd_full),
        .o_q_push        (cmd_push),
        .o_q_data        (cmd_in),
        .o_empty_density (empty_density)
    );

    vgts_fifo #(
        .WIDTH ($bits(vgts_pkg::t_cmd)),
        .DEPTH (vgts_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    vgts_back #(
        .MAX_EXTENT    (MAX_EXTENT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (cmd_out),
        .i_q_empty       (cmd_empty),
        .o_q_pop         (cmd_pop),
        .i_res_full      (res_full),
        .o_res_push      (res_push),
        .o_res_data      (res_in),
        .i_empty_density (empty_density)
    );

    vgts_fifo #(
        .WIDTH ($bits(vgts_pkg::t_res)),
        .DEPTH (vgts_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_rdata (res_out),
        .o_empty (o_empty)
    );

    assign o_full            = cmd_full;
    assign o_sampled_density = res_out.density;
    assign o_write_dropped   = res_out.dropped;

    `VGTS_ASSERT_IMPLIES(a_cmd_push_room, i_clk, i_rst_n, cmd_push, !cmd_full)
    `VGTS_ASSERT_IMPLIES(a_cmd_pop_valid, i_clk, i_rst_n, cmd_pop, !cmd_empty)
    `VGTS_ASSERT_IMPLIES(a_res_push_room, i_clk, i_rst_n, res_push, !res_full)
    `VGTS_ASSERT_NEXT(a_res_visible, i_clk, i_rst_n, res_push, !o_empty)

endmodule

FILE: hdl/vgts_ram.sv
// Generic single-port RAM with registered read data.
module vgts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/vgts_fifo.sv
// Small register-based FIFO used for the command and result queues.
module vgts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

FILE: hdl/vgts_front.sv
// Front end: configuration registers and classification of accepted items.
module vgts_front #(
    parameter int MAX_EXTENT    = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_op,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [vgts_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [vgts_pkg::DENS_W-1:0]  i_new_density,
    input  logic                                i_cfg_we,
    input  logic [vgts_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [vgts_pkg::DENS_W-1:0]         i_cfg_wdata,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output vgts_pkg::t_cmd                      o_q_data,
    output logic signed [vgts_pkg::DENS_W-1:0]  o_empty_density
);

    localparam int FB = FRACTION_BITS;
    localparam int PW = (FB >= vgts_pkg::POS_W) ? FB + 1 : vgts_pkg::POS_W;
    localparam int CW = PW - FB;
    localparam int AW = $clog2(MAX_EXTENT);
    localparam int LW = ($clog2(MAX_EXTENT + 1) > vgts_pkg::EXT_W) ?
                        $clog2(MAX_EXTENT + 1) : vgts_pkg::EXT_W;
    localparam int KW = ((CW + 1) > (LW + 1)) ? CW + 1 : LW + 1;

    localparam logic [LW-1:0] MAX_LIM = LW'(MAX_EXTENT);
    localparam logic [vgts_pkg::EXT_W-1:0] EXT_RESET = vgts_pkg::EXT_W'(32);

    localparam logic [vgts_pkg::CFG_IDX_W-1:0] CFG_EXTENT_X  = vgts_pkg::CFG_IDX_W'(0);
    localparam logic [vgts_pkg::CFG_IDX_W-1:0] CFG_EXTENT_Y  = vgts_pkg::CFG_IDX_W'(1);
    localparam logic [vgts_pkg::CFG_IDX_W-1:0] CFG_EXTENT_Z  = vgts_pkg::CFG_IDX_W'(2);
    localparam logic [vgts_pkg::CFG_IDX_W-1:0] CFG_EMPTY     = vgts_pkg::CFG_IDX_W'(3);
    localparam logic                           OP_SAMPLE     = 1'b1;

    typedef struct packed {
        logic                          lo_ok;
        logic                          hi_ok;
        logic [vgts_pkg::IDX_W-1:0]    i0;
        logic [vgts_pkg::IDX_W-1:0]    i1;
        logic [vgts_pkg::FRAC_W-1:0]   frac;
    } t_axis;

    logic [vgts_pkg::EXT_W-1:0]         r_ext_x;
    logic [vgts_pkg::EXT_W-1:0]         r_ext_y;
    logic [vgts_pkg::EXT_W-1:0]         r_ext_z;
    logic signed [vgts_pkg::DENS_W-1:0] r_empty;
    t_axis                              ax_x;
    t_axis                              ax_y;
    t_axis                              ax_z;

    function automatic logic [LW-1:0] clamp_ext(input logic [vgts_pkg::EXT_W-1:0] e);
        logic [LW-1:0] ext;
        ext = LW'(e);
        return (ext > MAX_LIM) ? MAX_LIM : ext;
    endfunction

    function automatic logic in_range(input logic signed [KW-1:0] c,
                                      input logic [LW-1:0] lim);
        logic signed [KW-1:0] lim_s;
        lim_s = $signed(KW'(lim));
        return (c >= 0) && (c < lim_s);
    endfunction

    function automatic t_axis classify(input logic signed [vgts_pkg::POS_W-1:0] p,
                                       input logic [LW-1:0] lim);
        logic signed [PW-1:0] pe;
        logic signed [KW-1:0] c0;
        logic signed [KW-1:0] c1;
        t_axis                a;
        pe      = PW'(p);
        c0      = KW'(pe >>> FB);
        c1      = c0 + KW'(1);
        a.lo_ok = in_range(c0, lim);
        a.hi_ok = in_range(c1, lim);
        a.i0    = vgts_pkg::IDX_W'(c0[AW-1:0]);
        a.i1    = vgts_pkg::IDX_W'(c1[AW-1:0]);
        a.frac  = vgts_pkg::FRAC_W'(pe[FB-1:0]);
        return a;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= EXT_RESET;
            r_ext_y <= EXT_RESET;
            r_ext_z <= EXT_RESET;
            r_empty <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_EXTENT_X: r_ext_x <= i_cfg_wdata[vgts_pkg::EXT_W-1:0];
                CFG_EXTENT_Y: r_ext_y <= i_cfg_wdata[vgts_pkg::EXT_W-1:0];
                CFG_EXTENT_Z: r_ext_z <= i_cfg_wdata[vgts_pkg::EXT_W-1:0];
                CFG_EMPTY:    r_empty <= $signed(i_cfg_wdata);
            endcase
        end
    end

    always_comb begin
        ax_x = classify(i_pos_x, clamp_ext(r_ext_x));
        ax_y = classify(i_pos_y, clamp_ext(r_ext_y));
        ax_z = classify(i_pos_z, clamp_ext(r_ext_z));

        o_q_data.sample                  = (i_op == OP_SAMPLE);
        o_q_data.lo_ok[vgts_pkg::AXIS_X] = ax_x.lo_ok;
        o_q_data.lo_ok[vgts_pkg::AXIS_Y] = ax_y.lo_ok;
        o_q_data.lo_ok[vgts_pkg::AXIS_Z] = ax_z.lo_ok;
        o_q_data.hi_ok[vgts_pkg::AXIS_X] = ax_x.hi_ok;
        o_q_data.hi_ok[vgts_pkg::AXIS_Y] = ax_y.hi_ok;
        o_q_data.hi_ok[vgts_pkg::AXIS_Z] = ax_z.hi_ok;
        o_q_data.x0                      = ax_x.i0;
        o_q_data.x1                      = ax_x.i1;
        o_q_data.y0                      = ax_y.i0;
        o_q_data.y1                      = ax_y.i1;
        o_q_data.z0                      = ax_z.i0;
        o_q_data.z1                      = ax_z.i1;
        o_q_data.fx                      = ax_x.frac;
        o_q_data.fy                      = ax_y.frac;
        o_q_data.fz                      = ax_z.frac;
        o_q_data.density                 = i_new_density;
    end

    assign o_q_push        = i_push && !i_q_full;
    assign o_empty_density = r_empty;

endmodule

FILE: hdl/vgts_back.sv
// Back end: cell memory, corner fetch sequencer and shared lerp unit.
module vgts_back #(
    parameter int MAX_EXTENT    = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vgts_pkg::t_cmd                      i_q_data,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  logic                                i_res_full,
    output logic                                o_res_push,
    output vgts_pkg::t_res                      o_res_data,
    input  logic signed [vgts_pkg::DENS_W-1:0]  i_empty_density
);

    localparam int FB        = FRACTION_BITS;
    localparam int AW        = $clog2(MAX_EXTENT);
    localparam int ADDR_W    = 3 * AW;
    localparam int CELLS     = 1 << ADDR_W;
    localparam int DIFF_W    = vgts_pkg::DENS_W + 1;
    localparam int PROD_W    = DIFF_W + FB + 1;
    localparam int NCORNER   = 8;
    localparam int NLERP     = 7;
    localparam int X_LERPS   = 4;
    localparam int XY_LERPS  = 6;
    localparam logic [2:0] LAST_CORNER = 3'(NCORNER - 1);
    localparam logic [2:0] LAST_STEP   = 3'(NLERP - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_READ  = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                             r_state;
    vgts_pkg::t_cmd                     r_cmd;
    logic [2:0]                         r_k;
    logic [2:0]                         r_step;
    logic [3:0]                         r_len;
    logic                               r_rd_pend;
    logic                               r_rd_ok;
    logic signed [vgts_pkg::DENS_W-1:0] r_vals [NCORNER];
    logic signed [vgts_pkg::DENS_W-1:0] r_a;
    logic signed [PROD_W-1:0]           r_prod;
    vgts_pkg::t_res                     r_res;

    logic [vgts_pkg::IDX_W-1:0]         xi;
    logic [vgts_pkg::IDX_W-1:0]         yi;
    logic [vgts_pkg::IDX_W-1:0]         zi;
    logic                               rd_ok;
    logic                               wr_ok;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_addr;
    logic [vgts_pkg::DENS_W-1:0]        ram_rdata;
    logic [FB-1:0]                      frac;
    logic signed [DIFF_W-1:0]           diff;
    logic signed [PROD_W-1:0]           prod;
    logic signed [vgts_pkg::DENS_W-1:0] sum;
    logic signed [vgts_pkg::DENS_W-1:0] fetched;

    // Corners are fetched in the order 0,4,2,6,1,5,3,7 so that every lerp takes
    // the two oldest values of the value line and appends its result.
    always_comb begin
        xi    = r_k[0] ? r_cmd.x1 : r_cmd.x0;
        yi    = r_k[1] ? r_cmd.y1 : r_cmd.y0;
        zi    = r_k[2] ? r_cmd.z1 : r_cmd.z0;
        rd_ok = (r_k[0] ? r_cmd.hi_ok[vgts_pkg::AXIS_X] : r_cmd.lo_ok[vgts_pkg::AXIS_X])
             && (r_k[1] ? r_cmd.hi_ok[vgts_pkg::AXIS_Y] : r_cmd.lo_ok[vgts_pkg::AXIS_Y])
             && (r_k[2] ? r_cmd.hi_ok[vgts_pkg::AXIS_Z] : r_cmd.lo_ok[vgts_pkg::AXIS_Z]);
        rd_addr = {xi[AW-1:0], yi[AW-1:0], zi[AW-1:0]};
        wr_ok   = &r_cmd.lo_ok;
        wr_addr = {r_cmd.x0[AW-1:0], r_cmd.y0[AW-1:0], r_cmd.z0[AW-1:0]};
        ram_we   = (r_state == S_WRITE) && wr_ok;
        ram_addr = (r_state == S_READ) ? rd_addr : wr_addr;

        priority if (r_step < 3'(X_LERPS)) begin
            frac = r_cmd.fx[FB-1:0];
        end else if (r_step < 3'(XY_LERPS)) begin
            frac = r_cmd.fy[FB-1:0];
        end else begin
            frac = r_cmd.fz[FB-1:0];
        end

        diff    = DIFF_W'(r_vals[1]) - DIFF_W'(r_vals[0]);
        prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
        sum     = r_a + vgts_pkg::DENS_W'(r_prod >>> FB);
        fetched = r_rd_ok ? $signed(ram_rdata) : i_empty_density;
    end

    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_res_data = r_res;

    vgts_ram #(
        .WIDTH (vgts_pkg::DENS_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_cmd.density),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_step    <= '0;
            r_len     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == S_READ);
            if (r_rd_pend) begin
                r_len <= r_len + 4'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_k     <= '0;
                        r_step  <= '0;
                        r_len   <= '0;
                        r_state <= i_q_data.sample ? S_READ : S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_READ: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == LAST_CORNER) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_len   <= r_len - 4'd2;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_len  <= r_len + 4'd1;
                    r_step <= r_step + 3'd1;
                    r_state <= (r_step == LAST_STEP) ? S_OUT : S_MUL;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= rd_ok;
        if (r_rd_pend) begin
            r_vals[r_len[2:0]] <= fetched;
        end
        if ((r_state == S_IDLE) && !i_q_empty) begin
            r_cmd <= i_q_data;
        end
        if (r_state == S_WRITE) begin
            r_res.density <= '0;
            r_res.dropped <= !wr_ok;
        end
        if (r_state == S_MUL) begin
            r_a    <= r_vals[0];
            r_prod <= prod;
            for (int i = 0; i < NCORNER - 2; i++) begin
                r_vals[i] <= r_vals[i+2];
            end
        end
        if (r_state == S_ADD) begin
            r_vals[r_len[2:0]] <= sum;
            if (r_step == LAST_STEP) begin
                r_res.density <= sum;
                r_res.dropped <= 1'b0;
            end
        end
    end

endmodule
